FILE: design/aum_pkg.sv
// Shared types, widths and the inexact 2x2 digit block of the approximate multiplier.
`default_nettype none
package aum_pkg;

  localparam int IN_WIDTH  = 17;
  localparam int OUT_WIDTH = 33;

  // Largest 2-bit digit and the inexact result of its square.
  localparam logic [1:0] DIGIT_MAX    = 2'd3;
  localparam logic [2:0] SQUARE_INEXACT = 3'd7;

  typedef logic signed [IN_WIDTH-1:0]  operand_t;
  typedef logic signed [OUT_WIDTH-1:0] product_t;

  // Exact 2x2 product except that 3*3 gives 7.
  function automatic logic [2:0] block2x2(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] exact;
    exact = 3'(a) * 3'(b);
    if (a == DIGIT_MAX && b == DIGIT_MAX) begin
      return SQUARE_INEXACT;
    end
    return exact;
  endfunction

endpackage
`default_nettype wire

FILE: design/approx_underdesigned_multiplier.sv
// Top level of the approximate 2x2-recursive sign-magnitude multiplier.
// An accepted operand beat passes the magnitude, row, group and output registers to the product port.
// Throughput: one operand beat per cycle while product_ready is high; four register stages, each one beat deep.
// A stalled product holds in the output register; upstream stages fill bubbles first.
// Reset (rst, synchronous) clears only the stage valid bits; no data is kept between beats.
`default_nettype none
module approx_underdesigned_multiplier #(
  parameter int OPERAND_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                operand_valid,
  output logic                     operand_ready,
  input  wire aum_pkg::operand_t   operand_a,
  input  wire aum_pkg::operand_t   operand_b,
  output logic                     product_valid,
  input  wire logic                product_ready,
  output aum_pkg::product_t        product
);
  import aum_pkg::*;

  // Clamp the width to the supported range; an operand port never carries
  // more than IN_WIDTH magnitude bits, so wider settings change nothing.
  localparam int CLAMPED  = (OPERAND_BITS < 2) ? 2 : ((OPERAND_BITS > 32) ? 32 : OPERAND_BITS);
  localparam int MAG_BITS = (CLAMPED > IN_WIDTH) ? IN_WIDTH : CLAMPED;
  // Number of 2-bit digits; zero digits above the magnitude add nothing, so
  // the power-of-two recursion collapses to these digits.
  localparam int DIGITS   = (MAG_BITS + 1) / 2;

  logic                  s1_valid, s1_ready, s1_neg;
  logic [2*DIGITS-1:0]   s1_mag_a, s1_mag_b;
  logic                  s2_valid, s2_ready, s2_neg;
  logic [2*DIGITS+1:0]   s2_rows [DIGITS];

  // Stage 1: sign of the result and masked magnitudes.
  aum_mag #(
    .MAG_BITS (MAG_BITS),
    .DIGITS   (DIGITS)
  ) u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operand_valid),
    .in_ready  (operand_ready),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .mag_a     (s1_mag_a),
    .mag_b     (s1_mag_b),
    .neg       (s1_neg)
  );

  // Stage 2: digit-block rows, one per digit of operand a.
  aum_rows #(
    .DIGITS (DIGITS)
  ) u_rows (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .mag_a     (s1_mag_a),
    .mag_b     (s1_mag_b),
    .in_neg    (s1_neg),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .rows      (s2_rows),
    .out_neg   (s2_neg)
  );

  // Stages 3 and 4: accumulate rows in groups, then total and apply the sign.
  aum_sum #(
    .DIGITS (DIGITS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .rows      (s2_rows),
    .in_neg    (s2_neg),
    .out_valid (product_valid),
    .out_ready (product_ready),
    .product   (product)
  );

endmodule
`default_nettype wire

FILE: design/aum_mag.sv
// Stage 1: sign decision and masked, digit-padded magnitudes.
`default_nettype none
module aum_mag #(
  parameter int MAG_BITS = 16,
  parameter int DIGITS   = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire aum_pkg::operand_t      operand_a,
  input  wire aum_pkg::operand_t      operand_b,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2*DIGITS-1:0]         mag_a,
  output logic [2*DIGITS-1:0]         mag_b,
  output logic                        neg
);
  import aum_pkg::*;

  localparam int PAD = 2 * DIGITS;

  logic [IN_WIDTH-1:0] ua, ub, abs_a, abs_b;
  logic                a_neg, b_neg, a_pos, b_pos;

  assign ua    = operand_a;
  assign ub    = operand_b;
  assign a_neg = ua[IN_WIDTH-1];
  assign b_neg = ub[IN_WIDTH-1];
  assign a_pos = !a_neg && (|ua[IN_WIDTH-2:0]);
  assign b_pos = !b_neg && (|ub[IN_WIDTH-2:0]);
  assign abs_a = a_neg ? (~ua + 1'b1) : ua;
  assign abs_b = b_neg ? (~ub + 1'b1) : ub;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      mag_a <= PAD'(abs_a[MAG_BITS-1:0]);
      mag_b <= PAD'(abs_b[MAG_BITS-1:0]);
      neg   <= (a_pos && b_neg) || (a_neg && b_pos);
    end
  end

endmodule
`default_nettype wire

FILE: design/aum_rows.sv
// Stage 2: one row per digit of a, each the shifted sum of its 2x2 digit blocks.
`default_nettype none
module aum_rows #(
  parameter int DIGITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2*DIGITS-1:0]   mag_a,
  input  wire logic [2*DIGITS-1:0]   mag_b,
  input  wire logic                  in_neg,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2*DIGITS+1:0]        rows [DIGITS],
  output logic                       out_neg
);
  import aum_pkg::*;

  localparam int ROW_W = 2 * DIGITS + 2;

  logic [ROW_W-1:0] rows_next [DIGITS];

  always_comb begin
    logic [ROW_W-1:0] acc;
    for (int i = 0; i < DIGITS; i++) begin
      acc = '0;
      for (int j = 0; j < DIGITS; j++) begin
        acc = acc + (ROW_W'(block2x2(mag_a[2*i +: 2], mag_b[2*j +: 2])) << (2 * j));
      end
      rows_next[i] = acc;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      rows    <= rows_next;
      out_neg <= in_neg;
    end
  end

endmodule
`default_nettype wire

FILE: design/aum_sum.sv
// Stages 3 and 4: group sums of shifted rows, then total, sign and output register.
`default_nettype none
module aum_sum #(
  parameter int DIGITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2*DIGITS+1:0]   rows [DIGITS],
  input  wire logic                  in_neg,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output aum_pkg::product_t          product
);
  import aum_pkg::*;

  localparam int GROUP = 3;
  localparam int NGRP  = (DIGITS + GROUP - 1) / GROUP;

  logic [OUT_WIDTH-1:0] grp_next [NGRP];
  logic [OUT_WIDTH-1:0] grp      [NGRP];
  logic                 grp_valid, grp_neg, grp_ready;
  logic [OUT_WIDTH-1:0] total;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (GROUP * g + k < DIGITS) begin
          grp_next[g] = grp_next[g]
                      + (OUT_WIDTH'(rows[GROUP*g+k]) << (2 * (GROUP * g + k)));
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + grp[g];
    end
  end

  assign grp_ready = !out_valid || out_ready;
  assign in_ready  = !grp_valid || grp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        grp_valid <= in_valid;
      end
      if (grp_ready) begin
        out_valid <= grp_valid;
      end
    end
    if (in_valid && in_ready) begin
      grp     <= grp_next;
      grp_neg <= in_neg;
    end
    if (grp_valid && grp_ready) begin
      product <= grp_neg ? product_t'(~total + 1'b1) : product_t'(total);
    end
  end

endmodule
`default_nettype wire

FILE: design/aum_checker.sv
// Port-level checker for the approximate multiplier, bound to the top level.
`default_nettype none
module aum_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              operand_valid,
  input wire logic              operand_ready,
  input wire aum_pkg::operand_t operand_a,
  input wire aum_pkg::operand_t operand_b,
  input wire logic              product_valid,
  input wire logic              product_ready,
  input wire aum_pkg::product_t product
);
  import aum_pkg::*;

  // A stalled product beat holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    product_valid && !product_ready |=> product_valid && $stable(product))
    else $error("product changed while stalled");

  // With the sink ready, every stage can advance, so input is never blocked.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    product_ready |-> operand_ready)
    else $error("operand_ready low while product_ready high");

  // A zero operand gives a zero product when the product side stays ready throughout.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (operand_valid && operand_ready && (operand_a == '0 || operand_b == '0)
     && product_ready) ##1 product_ready ##1 product_ready ##1 product_ready
    |=> product_valid && product == '0)
    else $error("zero operand gave nonzero product");

  // Operands of the same sign never give a negative product.
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (operand_valid && operand_ready && (operand_a[IN_WIDTH-1] == operand_b[IN_WIDTH-1])
     && product_ready) ##1 product_ready ##1 product_ready ##1 product_ready
    |=> product_valid && !product[OUT_WIDTH-1])
    else $error("same-sign operands gave negative product");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !product_valid)
    else $error("product_valid after reset");

endmodule

bind approx_underdesigned_multiplier aum_checker u_aum_checker (.*);
`default_nettype wire

FILE: test/tb_approx_underdesigned_multiplier.sv
// Self-checking bench for the approximate 2x2-recursive multiplier: directed table, then random beats.
`default_nettype none
module tb_approx_underdesigned_multiplier;
  import aum_pkg::*;

  // Magnitude width under test, shared by the instance and the predictor.
  localparam int OPERAND_BITS = 16;
  // Cycles with no product beat taken, while the operand side keeps offering.
  localparam int HOLD_CYCLES = 250;
  // Cycles allowed after the last expected product before the final verdict.
  localparam int DRAIN_CYCLES = 24;
  // Cap on the whole run.
  localparam int CYCLE_LIMIT = 200000;
  // Random beats per idling phase.
  localparam int BEATS_PER_PHASE = 300;
  localparam int MAX_REPORTS = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     operand_valid = 1'b0;
  logic     operand_ready;
  operand_t operand_a = '0;
  operand_t operand_b = '0;
  logic     product_valid;
  logic     product_ready = 1'b0;
  product_t product;

  approx_underdesigned_multiplier #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .operand_valid(operand_valid),
    .operand_ready(operand_ready),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .product_valid(product_valid),
    .product_ready(product_ready),
    .product      (product)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Products owed by the block, oldest first.
  product_t pending_products[$];
  product_t owed_product;

  int send_idle_pct = 6;
  int recv_idle_pct = 79;
  logic hold_go = 1'b0;
  int hold_left = HOLD_CYCLES;

  int cycle_count = 0;
  int beats_sent = 0;
  int products_checked = 0;
  int fail_count = 0;

  // Predict the approximate product: split both magnitudes into 2-bit digits,
  // multiply each digit pair with 3*3 taken as 7, and sum them at the weight
  // of both digit positions. The digit tree spans the next power of two.
  function automatic product_t approx_product(input operand_t a, input operand_t b);
    int unsigned      bits;
    int unsigned      tree;
    int unsigned      shift;
    longint           sa;
    longint           sb;
    longint unsigned  mag_a;
    longint unsigned  mag_b;
    longint unsigned  mask;
    longint unsigned  acc;
    longint unsigned  digit_prod;
    logic [1:0]       da;
    logic [1:0]       db;
    logic             flip;
    bits = OPERAND_BITS;
    if (OPERAND_BITS < 2) begin
      bits = 2;
    end
    if (OPERAND_BITS > 32) begin
      bits = 32;
    end
    tree = 2;
    while (tree < bits) begin
      tree = tree << 1;
    end
    sa = a;
    sb = b;
    mask = (64'd1 << bits) - 64'd1;
    // Drop magnitude bits above the operand width (e.g. 65536 from -65536).
    mag_a = ((sa < 0) ? -sa : sa) & mask;
    mag_b = ((sb < 0) ? -sb : sb) & mask;
    acc = 0;
    for (int i = 0; i < tree / 2; i++) begin
      da = mag_a[2*i +: 2];
      for (int j = 0; j < tree / 2; j++) begin
        db = mag_b[2*j +: 2];
        shift = 2 * (i + j);
        digit_prod = (da == 2'd3 && db == 2'd3) ? 64'd7 : 64'(da) * 64'(db);
        if (shift < 64) begin
          acc = acc + (digit_prod << shift);
        end
      end
    end
    // A zero operand never flips the sign.
    flip = (sa > 0 && sb < 0) || (sa < 0 && sb > 0);
    if (flip) begin
      acc = 64'd0 - acc;
    end
    return product_t'(acc[OUT_WIDTH-1:0]);
  endfunction

  // Pick an operand: extremes, digit patterns heavy in 3s, or any 17-bit value.
  function automatic operand_t pick_operand();
    operand_t    v;
    logic [15:0] mag;
    int          mode;
    mode = $urandom_range(9);
    if (mode == 0) begin
      case ($urandom_range(6))
        0: v = 17'sd0;
        1: v = 17'sd65535;
        2: v = -17'sd65535;
        3: v = operand_t'(17'h10000);
        4: v = 17'sd1;
        5: v = -17'sd1;
        default: v = 17'sd3;
      endcase
    end else if (mode <= 3) begin
      for (int d = 0; d < 8; d++) begin
        mag[2*d +: 2] = ($urandom_range(2) != 0) ? 2'd3 : 2'($urandom_range(3));
      end
      v = operand_t'({1'b0, mag});
      if ($urandom_range(1) != 0) begin
        v = -v;
      end
    end else begin
      v = operand_t'($urandom);
    end
    return v;
  endfunction

  // Offer one operand beat, idling first at the current rate, and hold it
  // until accepted; log what the block owes for it at the accepting edge.
  task automatic offer_beat(input operand_t a, input operand_t b, input product_t owed);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_valid <= 1'b0;
      @(posedge clk);
    end
    operand_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!operand_ready) begin
      @(posedge clk);
    end
    pending_products.push_back(owed);
    beats_sent++;
  endtask

  // Hold off the sender until every owed product beat has come back.
  task automatic drain_products();
    operand_valid <= 1'b0;
    while (pending_products.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Product side: random back-pressure, plus one long hold once requested.
  always @(posedge clk) begin
    if (hold_go && hold_left > 0) begin
      product_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      product_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted product beat against the oldest owed value.
  always @(posedge clk) begin
    if (!rst && product_valid && product_ready) begin
      if (pending_products.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("ERROR: product beat %0d with nothing owed", product);
        end
      end else begin
        owed_product = pending_products.pop_front();
        products_checked++;
        if (product !== owed_product) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("ERROR: product mismatch: expected %0d, got %0d", owed_product, product);
          end
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d products owed", cycle_count,
               pending_products.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed table: a literal product only where it is obvious, else predicted.
  typedef struct {
    operand_t a;
    operand_t b;
    logic     literal;
    product_t value;
  } vector_t;

  localparam int NUM_VECTORS = 22;
  vector_t vectors[NUM_VECTORS] = '{
    '{17'sd0,       17'sd0,       1'b1, 33'sd0},
    '{17'sd0,       -17'sd65535,  1'b1, 33'sd0},    // zero against a negative
    '{-17'sd65535,  17'sd0,       1'b1, 33'sd0},
    '{17'sd1,       17'sd1,       1'b1, 33'sd1},
    '{17'sd1,       -17'sd1,      1'b1, -33'sd1},
    '{-17'sd1,      -17'sd1,      1'b1, 33'sd1},
    '{17'sd3,       17'sd3,       1'b1, 33'sd7},    // the one inexact digit pair
    '{-17'sd3,      17'sd3,       1'b1, -33'sd7},
    '{17'sd2,       17'sd3,       1'b1, 33'sd6},
    '{-17'sd65536,  17'sd5,       1'b1, 33'sd0},    // magnitude too wide drops to 0
    '{17'sd5,       -17'sd65536,  1'b1, 33'sd0},
    '{-17'sd65536,  -17'sd65536,  1'b1, 33'sd0},
    '{17'sd65535,   17'sd1,       1'b1, 33'sd65535},
    '{-17'sd65535,  17'sd1,       1'b1, -33'sd65535},
    '{17'sd32768,   -17'sd32768,  1'b1, -33'sd1073741824},
    '{17'sd65535,   17'sd65535,   1'b0, 33'sd0},
    '{-17'sd65535,  17'sd65535,   1'b0, 33'sd0},
    '{-17'sd65535,  -17'sd65535,  1'b0, 33'sd0},
    '{17'sd21845,   17'sd21845,   1'b0, 33'sd0},
    '{17'sd43690,   -17'sd43690,  1'b0, 33'sd0},
    '{17'sd65535,   17'sd3,       1'b0, 33'sd0},
    '{-17'sd52428,  17'sd13107,   1'b0, 33'sd0}
  };

  operand_t next_a;
  operand_t next_b;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table under the first idling mix.
    for (int v = 0; v < NUM_VECTORS; v++) begin
      offer_beat(vectors[v].a, vectors[v].b,
                 vectors[v].literal ? vectors[v].value
                                    : approx_product(vectors[v].a, vectors[v].b));
    end

    // Three idling mixes; drain between them so the sender also pauses on empty.
    for (int phase = 0; phase < 3; phase++) begin
      drain_products();
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Stall the product side for a long stretch while beats keep coming.
          hold_go = 1'b1;
        end
      endcase
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        next_a = pick_operand();
        next_b = pick_operand();
        offer_beat(next_a, next_b, approx_product(next_a, next_b));
      end
    end

    drain_products();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d operand beats and %0d checked products across three",
             beats_sent, products_checked);
    $display("back-pressure mixes, one long product stall and %0d cycles.", cycle_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
